// ===== hdl/spa_pkg.sv =====
package spa_pkg;

    // table geometry
    localparam int MAX_TERMS = 32;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COEF_W    = 32;
    localparam int EXP_W     = 16;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    // one stored term
    typedef struct packed {
        logic signed [EXP_W-1:0]  exp;
        logic signed [COEF_W-1:0] coef;
    } t_term;

    localparam int TERM_W = $bits(t_term);

    // request codes
    typedef enum logic [1:0] {
        REQ_TERM  = 2'd0,
        REQ_PROD  = 2'd1,
        REQ_DRAIN = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_MERGED    = 3'd1,
        STAT_CANCELLED = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_DRAINED   = 3'd4,
        STAT_EMPTY     = 3'd5
    } t_status;

    // shared compare / add unit result
    typedef struct packed {
        logic                     lt;
        logic                     eq;
        logic signed [COEF_W-1:0] sum;
        logic                     zero;
    } t_unit_res;

endpackage

// ===== hdl/spa_ram.sv =====
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/spa_unit.sv =====
module spa_unit (
    input  spa_pkg::t_term                       i_stored,
    input  logic signed [spa_pkg::EXP_W-1:0]     i_exp,
    input  logic signed [spa_pkg::COEF_W-1:0]    i_coef,
    output spa_pkg::t_unit_res                   o_res
);

    logic signed [spa_pkg::COEF_W-1:0] sum;

    // compare exponents and add coefficients of stored and offered term
    assign sum         = i_stored.coef + i_coef;
    assign o_res.lt    = i_stored.exp < i_exp;
    assign o_res.eq    = i_stored.exp == i_exp;
    assign o_res.sum   = sum;
    assign o_res.zero  = sum == '0;

endmodule

// ===== hdl/sparse_polynomial_accumulator_top.sv =====
// Channel   Direction  Handshake              Payload
// request   in         start & !busy          i_req_type, i_coef_a, i_exp_a, i_coef_b, i_exp_b
// result    out        o_valid, one cycle     o_term_coef, o_term_exp, o_last, o_status
//
// Accumulate: the request is accepted, then a linear search over the table at one entry a
// cycle through the term RAM read port, then a shift of the tail at one entry a cycle
// when a term is inserted before it or cancelled. Search and shift touch each entry
// at most once. Drain: one beat per stored term, one beat a cycle; an empty table
// gives a single beat with status EMPTY.
// Reset clears the term count and the sequencer; the RAM keeps its contents.
// Results are strobes with no back pressure; busy stays high until the last beat.
module sparse_polynomial_accumulator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_req_type,
    input  logic signed [31:0]                   i_coef_a,
    input  logic signed [14:0]                   i_exp_a,
    input  logic signed [31:0]                   i_coef_b,
    input  logic signed [14:0]                   i_exp_b,
    output logic                                 o_valid,
    output logic signed [31:0]                   o_term_coef,
    output logic signed [15:0]                   o_term_exp,
    output logic                                 o_last,
    output logic [2:0]                           o_status
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_DEL    = 6'b000100,
        ST_INS    = 6'b001000,
        ST_PUT    = 6'b010000,
        ST_DRAIN  = 6'b100000
    } t_state;

    t_state                                  r_state, n_state;
    spa_pkg::t_cnt                           r_count, n_count;
    spa_pkg::t_cnt                           r_pos, n_pos;
    spa_pkg::t_cnt                           r_idx, n_idx;
    logic signed [spa_pkg::COEF_W-1:0]       r_coef, n_coef;
    logic signed [spa_pkg::EXP_W-1:0]        r_exp, n_exp;

    logic                                    r_valid, n_valid;
    logic signed [spa_pkg::COEF_W-1:0]       r_ocoef, n_ocoef;
    logic signed [spa_pkg::EXP_W-1:0]        r_oexp, n_oexp;
    logic                                    r_last, n_last;
    spa_pkg::t_status                        r_status, n_status;

    spa_pkg::t_cnt                           raddr_full;
    spa_pkg::t_cnt                           waddr_full;
    logic                                    ram_we;
    spa_pkg::t_term                          ram_wdata;
    spa_pkg::t_term                          ram_rdata;
    spa_pkg::t_unit_res                      unit_res;
    logic                                    full;

    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::MAX_TERMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_full[spa_pkg::ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (raddr_full[spa_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    spa_unit u_unit (
        .i_stored (ram_rdata),
        .i_exp    (r_exp),
        .i_coef   (r_coef),
        .o_res    (unit_res)
    );

    assign full = r_count == spa_pkg::t_cnt'(spa_pkg::MAX_TERMS);

    // sequence search, shift and drain
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_coef     = r_coef;
        n_exp      = r_exp;
        n_valid    = 1'b0;
        n_ocoef    = r_ocoef;
        n_oexp     = r_oexp;
        n_last     = r_last;
        n_status   = r_status;
        raddr_full = '0;
        waddr_full = r_pos;
        ram_we     = 1'b0;
        ram_wdata  = '{exp: r_exp, coef: r_coef};

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_pos = '0;
                    case (spa_pkg::t_req'(i_req_type))
                        spa_pkg::REQ_TERM: begin
                            n_coef  = i_coef_a;
                            n_exp   = {i_exp_a[14], i_exp_a};
                            n_state = ST_SEARCH;
                        end
                        spa_pkg::REQ_PROD: begin
                            n_coef  = i_coef_a * i_coef_b;
                            n_exp   = {i_exp_a[14], i_exp_a} + {i_exp_b[14], i_exp_b};
                            n_state = ST_SEARCH;
                        end
                        spa_pkg::REQ_DRAIN: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_ocoef  = '0;
                                n_oexp   = '0;
                                n_last   = 1'b1;
                                n_status = spa_pkg::STAT_EMPTY;
                            end else begin
                                n_state = ST_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                if (r_pos != r_count && unit_res.lt) begin
                    // advance past smaller exponent
                    n_pos      = r_pos + spa_pkg::t_cnt'(1);
                    raddr_full = r_pos + spa_pkg::t_cnt'(1);
                end else if (r_pos != r_count && unit_res.eq) begin
                    if (!unit_res.zero) begin
                        // merge in place
                        ram_we         = 1'b1;
                        ram_wdata.coef = unit_res.sum;
                        n_valid        = 1'b1;
                        n_ocoef        = unit_res.sum;
                        n_oexp         = r_exp;
                        n_last         = 1'b1;
                        n_status       = spa_pkg::STAT_MERGED;
                        n_state        = ST_IDLE;
                    end else begin
                        // cancel: drop entry and close the gap
                        n_count = r_count - spa_pkg::t_cnt'(1);
                        if (r_pos + spa_pkg::t_cnt'(1) < r_count) begin
                            n_idx      = r_pos;
                            raddr_full = r_pos + spa_pkg::t_cnt'(1);
                            n_state    = ST_DEL;
                        end else begin
                            n_valid  = 1'b1;
                            n_ocoef  = '0;
                            n_oexp   = r_exp;
                            n_last   = 1'b1;
                            n_status = spa_pkg::STAT_CANCELLED;
                            n_state  = ST_IDLE;
                        end
                    end
                end else if (full) begin
                    // drop new exponent
                    n_valid  = 1'b1;
                    n_ocoef  = r_coef;
                    n_oexp   = r_exp;
                    n_last   = 1'b1;
                    n_status = spa_pkg::STAT_FULL;
                    n_state  = ST_IDLE;
                end else if (r_pos == r_count) begin
                    n_state = ST_PUT;
                end else begin
                    // open a slot at pos, moving the tail up from the top
                    n_idx      = r_count;
                    raddr_full = r_count - spa_pkg::t_cnt'(1);
                    n_state    = ST_INS;
                end
            end

            ST_DEL: begin
                ram_we     = 1'b1;
                waddr_full = r_idx;
                ram_wdata  = ram_rdata;
                if (r_idx + spa_pkg::t_cnt'(1) < r_count) begin
                    n_idx      = r_idx + spa_pkg::t_cnt'(1);
                    raddr_full = r_idx + spa_pkg::t_cnt'(2);
                end else begin
                    n_valid  = 1'b1;
                    n_ocoef  = '0;
                    n_oexp   = r_exp;
                    n_last   = 1'b1;
                    n_status = spa_pkg::STAT_CANCELLED;
                    n_state  = ST_IDLE;
                end
            end

            ST_INS: begin
                ram_we     = 1'b1;
                waddr_full = r_idx;
                ram_wdata  = ram_rdata;
                if (r_idx - spa_pkg::t_cnt'(1) > r_pos) begin
                    n_idx      = r_idx - spa_pkg::t_cnt'(1);
                    raddr_full = r_idx - spa_pkg::t_cnt'(2);
                end else begin
                    n_state = ST_PUT;
                end
            end

            ST_PUT: begin
                ram_we   = 1'b1;
                n_count  = r_count + spa_pkg::t_cnt'(1);
                n_valid  = 1'b1;
                n_ocoef  = r_coef;
                n_oexp   = r_exp;
                n_last   = 1'b1;
                n_status = spa_pkg::STAT_INSERTED;
                n_state  = ST_IDLE;
            end

            ST_DRAIN: begin
                // emit one stored term a beat
                n_valid  = 1'b1;
                n_ocoef  = ram_rdata.coef;
                n_oexp   = ram_rdata.exp;
                n_status = spa_pkg::STAT_DRAINED;
                n_last   = r_pos + spa_pkg::t_cnt'(1) == r_count;
                if (r_pos + spa_pkg::t_cnt'(1) == r_count) begin
                    n_count = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_pos      = r_pos + spa_pkg::t_cnt'(1);
                    raddr_full = r_pos + spa_pkg::t_cnt'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_coef   <= n_coef;
        r_exp    <= n_exp;
        r_ocoef  <= n_ocoef;
        r_oexp   <= n_oexp;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign busy        = r_state != ST_IDLE;
    assign o_valid     = r_valid;
    assign o_term_coef = r_ocoef;
    assign o_term_exp  = r_oexp;
    assign o_last      = r_last;
    assign o_status    = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spa_pkg::t_cnt'(spa_pkg::MAX_TERMS))
        else $error("term count beyond table size");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_state == ST_IDLE))
        else $error("final beat while sequencer still running");

    a_drain_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |=> r_valid)
        else $error("drain stopped before final beat");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != ST_IDLE && r_state != ST_DRAIN))
        else $error("table write outside update states");

endmodule
